@@ hw/rtl/fcce_pkg.sv @@
// Shared types and constants for the block allocation table engine.
package fcce_pkg;

  localparam int NUM_BLOCKS_DEF  = 256;
  localparam int BLOCK_BYTES_DEF = 512;

  localparam int KIND_W  = 2;
  localparam int INDEX_W = 8;
  localparam int BYTES_W = 16;
  localparam int SKIP_W  = 8;
  localparam int CFG_W   = 9;
  localparam int STAT_W  = 2;
  localparam int TOUCH_W = 9;

  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  typedef enum logic [KIND_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_APPEND = 2'd1,
    OP_FREE   = 2'd2,
    OP_FOLLOW = 2'd3
  } op_t;

  localparam logic [1:0] ENT_FREE = 2'd0;
  localparam logic [1:0] ENT_END  = 2'd1;
  localparam logic [1:0] ENT_LINK = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_EOC  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd3;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic start;
    logic scan_step;
    logic finish;
    logic walk_rd;
    logic walk_chk;
    logic report;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_alloc;
    logic start_reject;
    logic chk_scan;
    logic chk_more;
    logic scan_done;
    logic scan_empty;
    logic out_room;
  } sts_t;

endpackage

@@ hw/rtl/fcce_ctrl.sv @@
// Control state machine of the allocation table engine.
module fcce_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fcce_pkg::sts_t  sts,
  output fcce_pkg::cmd_t  cmd
);
  import fcce_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_START    = 8'b0000_0100,
    S_SCAN     = 8'b0000_1000,
    S_FINISH   = 8'b0001_0000,
    S_WALK_RD  = 8'b0010_0000,
    S_WALK_CHK = 8'b0100_0000,
    S_REPORT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        if (sts.is_alloc)          state_next = S_SCAN;
        else if (sts.start_reject) state_next = S_REPORT;
        else                       state_next = S_WALK_RD;
      end
      S_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_next  = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        cmd.walk_chk = 1'b1;
        if (sts.chk_more)      state_next = S_WALK_RD;
        else if (sts.chk_scan) state_next = S_SCAN;
        else                   state_next = S_REPORT;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done)       state_next = S_FINISH;
        else if (sts.scan_empty) state_next = S_REPORT;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (sts.out_room) begin
          cmd.report = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

@@ hw/rtl/fcce_datapath.sv @@
// Datapath of the allocation table engine: table memory, walk and scan registers, result register.
module fcce_datapath #(
  parameter int NUM_BLOCKS  = fcce_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = fcce_pkg::BLOCK_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fcce_pkg::cmd_t                 cmd,
  output fcce_pkg::sts_t                 sts,
  input  logic [fcce_pkg::KIND_W-1:0]    in_kind,
  input  logic [fcce_pkg::INDEX_W-1:0]   in_block_index,
  input  logic [fcce_pkg::BYTES_W-1:0]   in_byte_count,
  input  logic [fcce_pkg::SKIP_W-1:0]    in_skip_count,
  input  logic                           cfg_valid,
  input  logic [fcce_pkg::CFG_W-1:0]     cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fcce_pkg::INDEX_W-1:0]   out_block,
  output logic [fcce_pkg::STAT_W-1:0]    out_status,
  output logic [fcce_pkg::TOUCH_W-1:0]   out_touched
);
  import fcce_pkg::*;

  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int CLOG_N = $clog2(NUM_BLOCKS + 1);
  localparam int CW     = (CLOG_N > CFG_W) ? CLOG_N : CFG_W;
  localparam int ACC_W  = $clog2((1 << BYTES_W) + BLOCK_BYTES);

  typedef struct packed {
    logic [1:0]       kind;
    logic [IDX_W-1:0] nxt;
  } entry_t;

  entry_t mem [NUM_BLOCKS];
  entry_t rd_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;

  logic [CFG_W-1:0]   cfg_reg;
  logic [IDX_W-1:0]   clr_ptr;
  op_t                kind;
  logic [INDEX_W-1:0] idx;
  logic [BYTES_W-1:0] bytes;
  logic [SKIP_W-1:0]  skips;
  logic [SKIP_W-1:0]  skip_n;
  logic [CW-1:0]      count;
  logic [CW-1:0]      touched;
  logic [ACC_W-1:0]   acc;
  logic [STAT_W-1:0]  status;
  logic [IDX_W-1:0]   blk;
  logic [IDX_W-1:0]   cur;
  logic [IDX_W-1:0]   cand;
  logic [CW-1:0]      scan_ptr;
  logic               pend;
  logic [IDX_W-1:0]   pend_addr;

  logic [CW-1:0]    cfg_cw;
  logic             idx_bad;
  logic             nx_bad;
  logic             walk_cont;
  logic             issue;
  logic             hit;
  logic             link_prev;
  logic [ACC_W-1:0] acc_new;

  // table memory
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

  assign cfg_cw    = CW'(cfg_reg);
  assign idx_bad   = CW'(idx) >= count;
  assign nx_bad    = (rd_data.nxt == '0) || (CW'(rd_data.nxt) >= count);
  assign walk_cont = (rd_data.kind != ENT_FREE) && (rd_data.kind != ENT_END) && !nx_bad;
  assign issue     = scan_ptr < count;
  assign hit       = pend && (rd_data.kind == ENT_FREE);
  assign link_prev = (touched != '0) || (kind == OP_APPEND);
  assign acc_new   = acc + ACC_W'(BLOCK_BYTES);

  always_comb begin
    sts            = '0;
    sts.clear_last = clr_ptr == IDX_W'(NUM_BLOCKS - 1);
    sts.is_alloc   = kind == OP_ALLOC;
    case (kind)
      OP_APPEND: sts.start_reject = idx_bad;
      OP_FREE:   sts.start_reject = (idx == '0) || idx_bad;
      OP_FOLLOW: sts.start_reject = idx_bad;
      default:   sts.start_reject = 1'b0;
    endcase
    sts.chk_scan   = (kind == OP_APPEND) && (rd_data.kind == ENT_END);
    case (kind)
      OP_FREE:   sts.chk_more = walk_cont;
      OP_FOLLOW: sts.chk_more = walk_cont && (skip_n != skips);
      default:   sts.chk_more = 1'b0;
    endcase
    sts.scan_done  = hit && ((kind == OP_APPEND) || (acc_new >= ACC_W'(bytes)));
    sts.scan_empty = !pend && !issue;
    sts.out_room   = !out_valid || out_ready;
  end

  always_comb begin
    rd_en   = cmd.walk_rd || (cmd.scan_step && issue);
    rd_addr = cmd.walk_rd ? cand : IDX_W'(scan_ptr);
  end

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    if (cmd.clear_step) begin
      we      = 1'b1;
      wa      = clr_ptr;
      wd.kind = (clr_ptr == '0) ? ENT_END : ENT_FREE;
    end else if (cmd.scan_step && hit && link_prev) begin
      we      = 1'b1;
      wa      = cur;
      wd.kind = ENT_LINK;
      wd.nxt  = pend_addr;
    end else if ((cmd.scan_step && sts.scan_empty && touched != '0) || cmd.finish) begin
      we      = 1'b1;
      wa      = cur;
      wd.kind = ENT_END;
    end else if (cmd.walk_chk && kind == OP_FREE && rd_data.kind != ENT_FREE) begin
      we      = 1'b1;
      wa      = cand;
      wd.kind = ENT_FREE;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg   <= CFG_RESET;
      clr_ptr   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) cfg_reg <= cfg_data;
      if (cmd.clear_step) clr_ptr <= clr_ptr + IDX_W'(1);
      if (cmd.report) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // operation registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind     <= op_t'(in_kind);
      idx      <= in_block_index;
      bytes    <= in_byte_count;
      skips    <= in_skip_count;
      count    <= (cfg_cw < CW'(NUM_BLOCKS)) ? cfg_cw : CW'(NUM_BLOCKS);
      status   <= ST_OK;
      touched  <= '0;
      acc      <= '0;
      blk      <= '0;
      skip_n   <= '0;
      cur      <= IDX_W'(in_block_index);
      cand     <= IDX_W'(in_block_index);
      scan_ptr <= CW'(1);
      pend     <= 1'b0;
    end
    if (cmd.start && sts.start_reject) status <= ST_BAD;
    if (cmd.walk_chk) begin
      case (kind)
        OP_APPEND: begin
          if (rd_data.kind != ENT_END) status <= ST_BAD;
        end
        OP_FREE: begin
          if (rd_data.kind == ENT_FREE) begin
            status <= ST_BAD;
          end else begin
            touched <= touched + CW'(1);
            if (rd_data.kind != ENT_END && nx_bad) status <= ST_BAD;
            if (walk_cont) cand <= rd_data.nxt;
          end
        end
        OP_FOLLOW: begin
          if (rd_data.kind == ENT_FREE) begin
            status <= ST_BAD;
            blk    <= cur;
          end else begin
            cur <= cand;
            blk <= cand;
            if (skip_n != skips) begin
              if (rd_data.kind == ENT_END) begin
                status <= ST_EOC;
              end else if (nx_bad) begin
                status <= ST_BAD;
              end else begin
                cand   <= rd_data.nxt;
                skip_n <= skip_n + SKIP_W'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (cmd.scan_step) begin
      pend      <= issue;
      pend_addr <= IDX_W'(scan_ptr);
      if (issue) scan_ptr <= scan_ptr + CW'(1);
      if (hit) begin
        if (touched == '0) blk <= pend_addr;
        cur     <= pend_addr;
        touched <= touched + CW'(1);
        acc     <= acc_new;
      end
      if (sts.scan_empty) status <= ST_FULL;
    end
    if (cmd.report) begin
      out_block   <= INDEX_W'(blk);
      out_status  <= status;
      out_touched <= touched[TOUCH_W-1:0];
    end
  end

endmodule

@@ hw/rtl/fat_cluster_chain_engine_core.sv @@
// Top level of the block allocation table engine.
// Keeps a table with one entry per block (free, end of chain, or link to
// the next block) and runs one operation per transaction: allocate a chain
// by first-fit from block 1, append one block to a chain tail, free a chain,
// or follow a number of links. After reset the table is cleared before the
// first transaction is taken. With count the smaller of blocks_in_use and
// NUM_BLOCKS, the first-fit scan reads one entry per cycle, from block 1 up
// to count - 1; free and follow visit each entry with one memory read and
// one check. A full result register stalls the engine before the result is
// loaded. One operation is in flight at a time; the result register lets
// the next transaction enter while a result is still waiting.
// blocks_in_use may be written only while the engine is idle.
module fat_cluster_chain_engine_core #(
  parameter int NUM_BLOCKS  = fcce_pkg::NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = fcce_pkg::BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // block_index[7:0], byte_count[23:8], skip_count[31:24]
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // block[7:0], status[9:8], blocks_touched[18:10], zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data        // blocks_in_use
);
  import fcce_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic [INDEX_W-1:0] out_block;
  logic [STAT_W-1:0]  out_status;
  logic [TOUCH_W-1:0] out_touched;

  assign cfg_ready = 1'b1;

  fcce_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fcce_datapath #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (s_axis_tuser),
    .in_block_index (s_axis_tdata[7:0]),
    .in_byte_count  (s_axis_tdata[23:8]),
    .in_skip_count  (s_axis_tdata[31:24]),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_block      (out_block),
    .out_status     (out_status),
    .out_touched    (out_touched)
  );

  assign m_axis_tdata = {5'd0, out_touched, out_status, out_block};

endmodule
